>>> sv/mtid_pkg.sv
// Package for the multitap interpolating delay line.
// Holds field widths, register codes, reset values and the transfer payload types.
// No dependencies.
package mtid_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int FRAC_BITS        = 8;
	localparam int INT_BITS         = 16;
	localparam int TAP_DELAY_W      = INT_BITS + FRAC_BITS;
	localparam int MAX_TAPS         = 16;
	localparam int TAP_NUM_W        = 4;
	localparam int TAP_CNT_W        = 5;
	localparam int BUFFER_DEPTH_DEF = 65536;

	localparam int CFG_DATA_W       = 17;
	localparam int CFG_IDX_W        = 1;
	localparam int LEN_RESET        = 48001;
	localparam int TAP_CNT_RESET    = 12;

	localparam int OUT_FIFO_DEPTH   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH = 1'b0,
		REG_TAP_COUNT    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_PUSH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                           cmd;
		logic signed [SAMPLE_BITS-1:0]  sample_in;
		logic [TAP_NUM_W-1:0]           tap_slot;
		logic [TAP_DELAY_W-1:0]         tap_delay;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0]  tap_value;
		logic [TAP_NUM_W-1:0]           tap_number;
		logic                           last;
	} result_t;

endpackage

>>> sv/multitap_interp_delay.sv
// A push is taken while the input is idle; its taps pass through the sequencer, then stages
// 0, 1 and 2, then the output queue. While its taps are issued the input stalls (one tap per
// cycle through the sample memory's two read ports, while the queue has room); a set item never stalls it.
// Results drain one per cycle, while result_stall is low, through an eight-entry output queue.
// Reset is asynchronous; samples never written read as zero through a fill mark,
// so no clearing pass is needed.
// Multitap delay line top level: sample memory, tap table, tap sequencer and
// interpolation pipeline. Depends on mtid_pkg.
module multitap_interp_delay #(
	parameter int BUFFER_DEPTH = mtid_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [mtid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtid_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  mtid_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output mtid_pkg::result_t                 result
);

	localparam int AW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int LW   = (AW + 1 > mtid_pkg::CFG_DATA_W) ? AW + 1 : mtid_pkg::CFG_DATA_W;
	localparam int F    = mtid_pkg::FRAC_BITS;
	localparam int SB   = mtid_pkg::SAMPLE_BITS;
	localparam int PW   = LW + F;
	localparam int DW   = (PW > mtid_pkg::TAP_DELAY_W) ? PW : mtid_pkg::TAP_DELAY_W;
	localparam int PRW  = SB + F + 2;
	localparam int SW   = PRW + 1;
	localparam int TIW  = mtid_pkg::TAP_NUM_W;
	localparam int TCW  = mtid_pkg::TAP_CNT_W;
	localparam int QD   = mtid_pkg::OUT_FIFO_DEPTH;
	localparam int QAW  = $clog2(QD);
	localparam int QCW  = QAW + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	logic [mtid_pkg::CFG_DATA_W-1:0] len_q;
	logic [TCW-1:0]                  tap_cnt_q;
	logic [AW-1:0]                   ptr_q;
	logic [LW-1:0]                   fill_q;
	logic [mtid_pkg::TAP_DELAY_W-1:0] tap_tab_q [mtid_pkg::MAX_TAPS];
	logic [TIW-1:0]                  idx_q;
	logic [TCW-1:0]                  taps_q;
	logic [QCW-1:0]                  occ_q;

	logic [SB-1:0]                   mem [BUFFER_DEPTH];

	logic                            item_xfer;
	logic                            result_xfer;
	logic                            push;
	logic                            issue;
	logic [LW-1:0]                   len_eff;
	logic [TCW-1:0]                  taps_eff;
	logic [LW-1:0]                   ptr_inc;
	logic [AW-1:0]                   ptr_next;
	logic                            issue_last;

	logic [PW-1:0]                   dmax;
	logic [DW-1:0]                   dly_x;
	logic [DW-1:0]                   dmax_x;

	logic                            vld_s0;
	logic [PW-1:0]                   d_s0;
	logic [TIW-1:0]                  tap_s0;
	logic                            last_s0;

	logic [PW-1:0]                   base;
	logic [PW-1:0]                   lenf;
	logic [PW:0]                     pos_w;
	logic [PW-1:0]                   pos;
	logic [AW-1:0]                   rd_a;
	logic [AW:0]                     a_inc;
	logic [AW-1:0]                   rd_b;

	logic                            vld_s1;
	logic [F-1:0]                    f_s1;
	logic                            aok_s1;
	logic                            bok_s1;
	logic [TIW-1:0]                  tap_s1;
	logic                            last_s1;
	logic [SB-1:0]                   mem_a_s1;
	logic [SB-1:0]                   mem_b_s1;

	logic signed [SB-1:0]            smp_a;
	logic signed [SB-1:0]            smp_b;
	logic [F:0]                      w_a;
	logic signed [F+1:0]             wa_s;
	logic signed [F+1:0]             wb_s;

	logic                            vld_s2;
	logic signed [PRW-1:0]           pa_s2;
	logic signed [PRW-1:0]           pb_s2;
	logic [TIW-1:0]                  tap_s2;
	logic                            last_s2;

	logic signed [SW-1:0]            sum;
	mtid_pkg::result_t               res_new;

	mtid_pkg::result_t               fifo_q [QD];
	logic [QAW-1:0]                  wr_q;
	logic [QAW-1:0]                  rd_q;
	logic [QCW-1:0]                  cnt_q;

	assign item_stall  = (state_q != ST_IDLE);
	assign item_xfer   = item_valid && !item_stall;
	assign push        = item_xfer && (item.cmd == mtid_pkg::CMD_PUSH);
	assign result_valid = (cnt_q != '0);
	assign result      = fifo_q[rd_q];
	assign result_xfer = result_valid && !result_stall;

	always_comb begin
		priority if (LW'(len_q) < LW'(2)) begin
			len_eff = LW'(2);
		end else if (LW'(len_q) > LW'(BUFFER_DEPTH)) begin
			len_eff = LW'(BUFFER_DEPTH);
		end else begin
			len_eff = LW'(len_q);
		end
		taps_eff = (tap_cnt_q > TCW'(mtid_pkg::MAX_TAPS)) ? TCW'(mtid_pkg::MAX_TAPS) : tap_cnt_q;
		ptr_inc  = LW'(ptr_q) + LW'(1);
		ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];
	end

	assign issue      = (state_q == ST_RUN) && (occ_q < QCW'(QD));
	assign issue_last = (TCW'(idx_q) + TCW'(1)) == taps_q;

	// config and tap table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= mtid_pkg::CFG_DATA_W'(mtid_pkg::LEN_RESET);
			tap_cnt_q <= TCW'(mtid_pkg::TAP_CNT_RESET);
			for (int i = 0; i < mtid_pkg::MAX_TAPS; i++) begin
				tap_tab_q[i] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				unique case (mtid_pkg::cfg_reg_t'(cfg_index))
					mtid_pkg::REG_DELAY_LENGTH: len_q     <= cfg_data;
					mtid_pkg::REG_TAP_COUNT:    tap_cnt_q <= cfg_data[TCW-1:0];
					default: ;
				endcase
			end
			if (item_xfer && (item.cmd == mtid_pkg::CMD_SET) &&
			    ((TIW + 1)'(item.tap_slot) < (TIW + 1)'(mtid_pkg::MAX_TAPS))) begin
				tap_tab_q[item.tap_slot] <= item.tap_delay;
			end
		end
	end

	// sequencer: write pointer, fill mark, tap index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
			taps_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						ptr_q <= ptr_next;
						if (LW'(ptr_q) == fill_q) begin
							fill_q <= fill_q + LW'(1);
						end
						idx_q  <= '0;
						taps_q <= taps_eff;
						if (taps_eff != '0) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						idx_q <= idx_q + TIW'(1);
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stage 0: saturate delay
	always_comb begin
		dmax   = {len_eff - LW'(1), F'(0)};
		dly_x  = DW'(tap_tab_q[idx_q]);
		dmax_x = DW'(dmax);
	end

	always_ff @(posedge clk) begin
		d_s0    <= (dly_x > dmax_x) ? dmax : PW'(dly_x);
		tap_s0  <= idx_q;
		last_s0 <= issue_last;
	end

	// stage 1: read position and neighbor addresses
	always_comb begin
		base  = {LW'(ptr_q), F'(0)};
		lenf  = {len_eff, F'(0)};
		pos_w = (base >= d_s0) ? ((PW + 1)'(base) - (PW + 1)'(d_s0))
		                       : ((PW + 1)'(base) + (PW + 1)'(lenf) - (PW + 1)'(d_s0));
		pos   = pos_w[PW-1:0];
		rd_a  = pos[F +: AW];
		a_inc = (AW + 1)'(rd_a) + (AW + 1)'(1);
		rd_b  = (LW'(a_inc) >= len_eff) ? '0 : a_inc[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[ptr_q] <= item.sample_in;
		end
		mem_a_s1 <= mem[rd_a];
		mem_b_s1 <= mem[rd_b];
	end

	always_ff @(posedge clk) begin
		f_s1    <= pos[F-1:0];
		aok_s1  <= LW'(rd_a) < fill_q;
		bok_s1  <= LW'(rd_b) < fill_q;
		tap_s1  <= tap_s0;
		last_s1 <= last_s0;
	end

	// stage 2: weight the neighbors
	always_comb begin
		smp_a = aok_s1 ? $signed(mem_a_s1) : '0;
		smp_b = bok_s1 ? $signed(mem_b_s1) : '0;
		w_a   = (F + 1)'(2 ** F) - (F + 1)'(f_s1);
		wa_s  = $signed({1'b0, w_a});
		wb_s  = $signed({2'b00, f_s1});
	end

	always_ff @(posedge clk) begin
		pa_s2   <= PRW'(smp_a) * PRW'(wa_s);
		pb_s2   <= PRW'(smp_b) * PRW'(wb_s);
		tap_s2  <= tap_s1;
		last_s2 <= last_s1;
	end

	// stage 3: round half up, floor shift
	always_comb begin
		sum                = SW'(pa_s2) + SW'(pb_s2) + SW'(2 ** (F - 1));
		res_new.tap_value  = sum[F +: SB];
		res_new.tap_number = tap_s2;
		res_new.last       = last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s0 <= issue;
			vld_s1 <= vld_s0;
			vld_s2 <= vld_s1;
		end
	end

	// output queue; occupancy counts every tap from issue to transfer
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			fifo_q[wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (vld_s2) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (result_xfer) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(vld_s2) - QCW'(result_xfer);
			occ_q <= occ_q + QCW'(issue) - QCW'(result_xfer);
		end
	end

endmodule

>>> sv/mtid_chk.sv
// Port-level checker for the multitap interpolating delay line, bound to the top level.
// Depends on mtid_pkg and multitap_interp_delay.
module mtid_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input mtid_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input mtid_pkg::result_t result
);

	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

	a_set_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.cmd == mtid_pkg::CMD_SET) |=> !item_stall)
		else $error("set transfer left input stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_number_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last |=>
			!result_valid || (result.tap_number != '0))
		else $error("tap numbering restarted before last");

endmodule

bind multitap_interp_delay mtid_chk u_mtid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> bench/tb_multitap_interp_delay.sv
// Self-checking bench for multitap_interp_delay: directed and random transfers under
// several idle and stall mixes, checked against an in-bench delay line predictor.
// Depends on mtid_pkg and multitap_interp_delay.
module tb_multitap_interp_delay;

	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 100;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [mtid_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mtid_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_stall;
	mtid_pkg::item_t                 item = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	mtid_pkg::result_t               result;

	bit signed [mtid_pkg::SAMPLE_BITS-1:0] hist_mem [mtid_pkg::BUFFER_DEPTH_DEF];
	bit [mtid_pkg::TAP_DELAY_W-1:0]        tap_delays [mtid_pkg::MAX_TAPS];
	int unsigned                           wr_ptr = 0;
	int unsigned                           delay_len = mtid_pkg::LEN_RESET;
	int unsigned                           tap_cnt = mtid_pkg::TAP_CNT_RESET;

	mtid_pkg::item_t   send_queue [$];
	mtid_pkg::result_t tap_results [$];
	mtid_pkg::result_t next_tap;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      err_count = 0;
	int      cycle_count = 0;

	multitap_interp_delay dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int unsigned eff_len();
		if (delay_len < 2)
			return 2;
		if (delay_len > mtid_pkg::BUFFER_DEPTH_DEF)
			return mtid_pkg::BUFFER_DEPTH_DEF;
		return delay_len;
	endfunction

	function automatic void predict_taps(input mtid_pkg::item_t it);
		int unsigned       len, taps, a, b;
		longint unsigned   dmax, d, base, pos, frac;
		longint            acc, q;
		mtid_pkg::result_t r;
		if (it.cmd == mtid_pkg::CMD_SET) begin
			tap_delays[it.tap_slot] = it.tap_delay;
			return;
		end
		len = eff_len();
		taps = (tap_cnt > mtid_pkg::MAX_TAPS) ? mtid_pkg::MAX_TAPS : tap_cnt;
		hist_mem[wr_ptr] = it.sample_in;
		wr_ptr = wr_ptr + 1;
		if (wr_ptr >= len)
			wr_ptr = 0;
		dmax = longint'(len - 1) << mtid_pkg::FRAC_BITS;
		base = longint'(wr_ptr) << mtid_pkg::FRAC_BITS;
		for (int i = 0; i < taps; i++) begin
			d = tap_delays[i];
			if (d > dmax)
				d = dmax;
			pos = (base >= d) ? base - d
			                  : base + (longint'(len) << mtid_pkg::FRAC_BITS) - d;
			a = 32'(pos >> mtid_pkg::FRAC_BITS);
			frac = pos & ((64'd1 << mtid_pkg::FRAC_BITS) - 1);
			if (a >= len)
				a = 0;
			b = a + 1;
			if (b >= len)
				b = 0;
			acc = longint'(hist_mem[a]) * longint'((64'd1 << mtid_pkg::FRAC_BITS) - frac)
				+ longint'(hist_mem[b]) * longint'(frac)
				+ longint'(64'd1 << (mtid_pkg::FRAC_BITS - 1));
			q = acc >>> mtid_pkg::FRAC_BITS;
			r.tap_value = q[mtid_pkg::SAMPLE_BITS-1:0];
			r.tap_number = mtid_pkg::TAP_NUM_W'(i);
			r.last = (i + 1 == taps);
			tap_results.push_back(r);
		end
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				predict_taps(item);
			if (!item_valid || !item_stall) begin
				if (send_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
					item <= send_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			result_stall <= ($urandom_range(99) < stall_pct);
			if (result_valid && !result_stall) begin
				if (tap_results.size() == 0) begin
					flag_error($sformatf("unexpected transfer: value %0d tap %0d last %0b",
						result.tap_value, result.tap_number, result.last));
				end else begin
					next_tap = tap_results.pop_front();
					if (result.tap_value !== next_tap.tap_value)
						flag_error($sformatf("tap %0d value got %0d want %0d",
							next_tap.tap_number, result.tap_value, next_tap.tap_value));
					if (result.tap_number !== next_tap.tap_number)
						flag_error($sformatf("tap number got %0d want %0d",
							result.tap_number, next_tap.tap_number));
					if (result.last !== next_tap.last)
						flag_error($sformatf("tap %0d last got %0b want %0b",
							next_tap.tap_number, result.last, next_tap.last));
				end
			end
		end
	end

	task automatic wait_idle();
		do begin
			while (send_queue.size() != 0 || item_valid || tap_results.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end while (send_queue.size() != 0 || item_valid || tap_results.size() != 0);
	endtask

	task automatic set_reg(input mtid_pkg::cfg_reg_t idx, input int unsigned value);
		wait_idle();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[mtid_pkg::CFG_DATA_W-1:0];
		unique case (idx)
			mtid_pkg::REG_DELAY_LENGTH: delay_len = value & 32'h1FFFF;
			mtid_pkg::REG_TAP_COUNT:    tap_cnt = value & 32'h1F;
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_push(input logic [mtid_pkg::SAMPLE_BITS-1:0] s);
		mtid_pkg::item_t it;
		it.cmd = mtid_pkg::CMD_PUSH;
		it.sample_in = s;
		it.tap_slot = mtid_pkg::TAP_NUM_W'($urandom_range(mtid_pkg::MAX_TAPS - 1));
		it.tap_delay = mtid_pkg::TAP_DELAY_W'($urandom_range(24'hFFFFFF));
		send_queue.push_back(it);
	endtask

	task automatic add_set(input int unsigned slot, input int unsigned d);
		mtid_pkg::item_t it;
		it.cmd = mtid_pkg::CMD_SET;
		it.sample_in = mtid_pkg::SAMPLE_BITS'($urandom_range(16'hFFFF));
		it.tap_slot = slot[mtid_pkg::TAP_NUM_W-1:0];
		it.tap_delay = d[mtid_pkg::TAP_DELAY_W-1:0];
		send_queue.push_back(it);
	endtask

	task automatic start_phase(input int idle, input int stall);
		@(negedge clk);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	task automatic run_block(input int count);
		int unsigned len, taps, span, d;
		case ($urandom_range(9))
			0: len = $urandom_range(1);
			1: len = mtid_pkg::BUFFER_DEPTH_DEF;
			2: len = $urandom_range(131071, mtid_pkg::BUFFER_DEPTH_DEF + 1);
			3: len = $urandom_range(131071);
			default: len = $urandom_range(40, 2);
		endcase
		case ($urandom_range(9))
			0: taps = 0;
			1: taps = $urandom_range(31, mtid_pkg::MAX_TAPS + 1);
			2: taps = mtid_pkg::MAX_TAPS;
			default: taps = $urandom_range(mtid_pkg::MAX_TAPS, 1);
		endcase
		set_reg(mtid_pkg::REG_DELAY_LENGTH, len);
		set_reg(mtid_pkg::REG_TAP_COUNT, taps);
		span = eff_len();
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0: d = $urandom_range(24'hFFFFFF);
					1: d = $urandom_range(span) << mtid_pkg::FRAC_BITS;
					default: d = $urandom_range((span << mtid_pkg::FRAC_BITS) + 300);
				endcase
				add_set($urandom_range(mtid_pkg::MAX_TAPS - 1), d);
			end else if ($urandom_range(9) == 0) begin
				add_push($urandom_range(1) ? 16'h7FFF : 16'h8000);
			end else begin
				add_push(mtid_pkg::SAMPLE_BITS'($urandom_range(16'hFFFF)));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		start_phase(0, 0);

		add_push(16'h7FFF);
		add_push(16'h8000);
		add_set(0, 24'h000100);
		add_set(1, 24'h000080);
		add_set(2, 24'h0001FF);
		add_set(3, 24'hFFFFFF);
		add_set(15, 24'h000001);
		add_set(4, 24'h00027F);
		set_reg(mtid_pkg::REG_TAP_COUNT, mtid_pkg::MAX_TAPS);
		set_reg(mtid_pkg::REG_DELAY_LENGTH, 5);
		add_push(16'h7FFF);
		add_push(16'h8000);
		add_push(16'h7FFF);
		add_push(16'h8000);
		add_push(16'h0000);
		add_push(16'hFFFF);
		add_push(16'h1234);
		set_reg(mtid_pkg::REG_TAP_COUNT, 0);
		add_push(16'h4321);
		set_reg(mtid_pkg::REG_TAP_COUNT, 31);
		add_push(16'h8000);
		set_reg(mtid_pkg::REG_DELAY_LENGTH, 0);
		add_push(16'h7FFF);
		add_push(16'h8000);
		set_reg(mtid_pkg::REG_DELAY_LENGTH, 131071);
		add_push(16'h7FFF);
		add_push(16'h8000);
		// pointer now sits past the new length
		set_reg(mtid_pkg::REG_DELAY_LENGTH, 1);
		add_push(16'h5555);

		run_block(44);
		run_block(44);
		start_phase(85, 0);
		run_block(44);
		run_block(44);
		start_phase(0, 85);
		run_block(44);
		run_block(44);
		start_phase(33, 33);
		run_block(44);
		run_block(44);

		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
sv/mtid_pkg.sv
sv/multitap_interp_delay.sv
sv/mtid_chk.sv
bench/tb_multitap_interp_delay.sv
